>>> sv/deqd_pkg.sv
// Shared types, constants and the ring index helper of the double-ended queue with delete.
package deqd_pkg;

  localparam int unsigned Depth   = 64;
  localparam int unsigned IdxW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned WordW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdPushBack  = 3'd0,
    CmdPopBack   = 3'd1,
    CmdPushFront = 3'd2,
    CmdPopFront  = 3'd3,
    CmdDelete    = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StMiss  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SExec,
    SPopRd,
    SScan,
    SShift,
    SResult
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] count;
    status_e           status;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [WordW-1:0] wdata;
    logic [IdxW-1:0]  raddr;
  } ram_req_t;

  // Ring slot of the entry at position pos counted from the front.
  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] head,
                                               input logic [CntW-1:0] pos);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - IdxW){1'b0}}, head} + {1'b0, pos};
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

>>> sv/deqd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module deqd_ram #(
  parameter  int unsigned Width = 32,
  parameter  int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/deqd_ctrl.sv
// Command sequencer: ring pointers, read-modify-write of the entry RAM, scan and compaction.
module deqd_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  deqd_pkg::cmd_e                      in_cmd_i,
  input  logic [deqd_pkg::WordW-1:0]          in_value_i,
  input  logic                                res_free_i,
  output deqd_pkg::result_t                   res_o,
  output deqd_pkg::ram_req_t                  ram_req_o,
  input  logic [deqd_pkg::WordW-1:0]          ram_rdata_i
);

  localparam logic [deqd_pkg::CntW-1:0] FullCnt = deqd_pkg::CntW'(deqd_pkg::Depth);
  localparam logic [deqd_pkg::IdxW-1:0] LastIdx = deqd_pkg::IdxW'(deqd_pkg::Depth - 1);
  localparam logic [deqd_pkg::CntW-1:0] One     = deqd_pkg::CntW'(1);
  localparam logic [deqd_pkg::CntW-1:0] Two     = deqd_pkg::CntW'(2);

  deqd_pkg::state_e              state_q, state_d;
  deqd_pkg::cmd_e                cmd_q, cmd_d;
  logic [deqd_pkg::WordW-1:0]    val_q, val_d;
  logic [deqd_pkg::IdxW-1:0]     head_q, head_d;
  logic [deqd_pkg::CntW-1:0]     occ_q, occ_d;
  logic [deqd_pkg::CntW-1:0]     idx_q, idx_d;
  logic [deqd_pkg::WordW-1:0]    popped_q, popped_d;
  deqd_pkg::status_e             status_q, status_d;

  logic empty, full, hit, more, more_shift;
  logic [deqd_pkg::IdxW-1:0] head_dec, head_inc;

  assign empty      = (occ_q == '0);
  assign full       = (occ_q == FullCnt);
  assign hit        = (ram_rdata_i == val_q);
  assign more       = ((idx_q + One) < occ_q);
  assign more_shift = ((idx_q + Two) < occ_q);
  assign head_dec   = (head_q == '0) ? LastIdx : head_q - deqd_pkg::IdxW'(1);
  assign head_inc   = (head_q == LastIdx) ? '0 : head_q + deqd_pkg::IdxW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deqd_pkg::SIdle: begin
        if (in_valid_i) state_d = deqd_pkg::SExec;
      end
      deqd_pkg::SExec: begin
        unique case (cmd_q)
          deqd_pkg::CmdPopBack, deqd_pkg::CmdPopFront: begin
            state_d = empty ? deqd_pkg::SResult : deqd_pkg::SPopRd;
          end
          deqd_pkg::CmdDelete: begin
            state_d = empty ? deqd_pkg::SResult : deqd_pkg::SScan;
          end
          default: state_d = deqd_pkg::SResult;
        endcase
      end
      deqd_pkg::SPopRd: state_d = deqd_pkg::SResult;
      deqd_pkg::SScan: begin
        if (hit && more) begin
          state_d = deqd_pkg::SShift;
        end else if (!more) begin
          state_d = deqd_pkg::SResult;
        end
      end
      deqd_pkg::SShift: begin
        if (!more_shift) state_d = deqd_pkg::SResult;
      end
      deqd_pkg::SResult: begin
        if (res_free_i) state_d = deqd_pkg::SIdle;
      end
      default: state_d = deqd_pkg::SIdle;
    endcase
  end

  always_comb begin
    cmd_d           = cmd_q;
    val_d           = val_q;
    head_d          = head_q;
    occ_d           = occ_q;
    idx_d           = idx_q;
    popped_d        = popped_q;
    status_d        = status_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = deqd_pkg::slot_of(head_q, idx_q);
    ram_req_o.wdata = val_q;
    ram_req_o.raddr = deqd_pkg::slot_of(head_q, idx_q + One);
    in_ready_o      = (state_q == deqd_pkg::SIdle);
    res_o.valid     = (state_q == deqd_pkg::SResult);
    res_o.word      = popped_q;
    res_o.count     = deqd_pkg::CountW'(occ_q);
    res_o.status    = status_q;
    unique case (state_q)
      deqd_pkg::SIdle: begin
        if (in_valid_i) begin
          cmd_d = in_cmd_i;
          val_d = in_value_i;
        end
      end
      deqd_pkg::SExec: begin
        popped_d = '0;
        status_d = deqd_pkg::StDone;
        idx_d    = '0;
        unique case (cmd_q)
          deqd_pkg::CmdPushBack: begin
            if (full) begin
              status_d = deqd_pkg::StFull;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = deqd_pkg::slot_of(head_q, occ_q);
              occ_d           = occ_q + One;
            end
          end
          deqd_pkg::CmdPushFront: begin
            if (full) begin
              status_d = deqd_pkg::StFull;
            end else begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = head_dec;
              head_d          = head_dec;
              occ_d           = occ_q + One;
            end
          end
          deqd_pkg::CmdPopBack: begin
            if (empty) begin
              status_d = deqd_pkg::StEmpty;
            end else begin
              ram_req_o.raddr = deqd_pkg::slot_of(head_q, occ_q - One);
              occ_d           = occ_q - One;
            end
          end
          deqd_pkg::CmdPopFront: begin
            if (empty) begin
              status_d = deqd_pkg::StEmpty;
            end else begin
              ram_req_o.raddr = head_q;
              head_d          = head_inc;
              occ_d           = occ_q - One;
            end
          end
          deqd_pkg::CmdDelete: begin
            ram_req_o.raddr = head_q;
            if (empty) status_d = deqd_pkg::StMiss;
          end
          default: ;
        endcase
      end
      deqd_pkg::SPopRd: popped_d = ram_rdata_i;
      deqd_pkg::SScan: begin
        if (hit) begin
          if (!more) occ_d = occ_q - One;
        end else if (more) begin
          idx_d = idx_q + One;
          ram_req_o.raddr = deqd_pkg::slot_of(head_q, idx_q + One);
        end else begin
          status_d = deqd_pkg::StMiss;
        end
      end
      deqd_pkg::SShift: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.wdata = ram_rdata_i;
        idx_d           = idx_q + One;
        ram_req_o.raddr = deqd_pkg::slot_of(head_q, idx_q + Two);
        if (!more_shift) occ_d = occ_q - One;
      end
      deqd_pkg::SResult: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deqd_pkg::SIdle;
      head_q  <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      occ_q   <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    popped_q <= popped_d;
    status_q <= status_d;
  end

endmodule

>>> sv/double_ended_queue_with_delete_unit.sv
// Top level of the double-ended queue with delete: stream ports, entry RAM and result register.
//
// Channel  Dir  Payload
// s_axis   in   tuser = command[2:0]; tdata = value[31:0]
// m_axis   out  tuser = status[1:0]; tdata = popped_word[31:0], entry_count[38:32]
//
// A push goes from acceptance through the execute and result states, a pop also
// through a read state, and a delete through a scan and a compaction that walk
// the entry RAM one read per cycle through its single read port.
// One item is worked on at a time; the next item is accepted while a result waits.
// Reset empties the queue at once; the entry RAM is not cleared.
module double_ended_queue_with_delete_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic [2:0]  s_axis_tuser_i,   // command[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // popped_word[31:0], entry_count[38:32], zero
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  deqd_pkg::result_t                res;
  deqd_pkg::ram_req_t               ram_req;
  logic [deqd_pkg::WordW-1:0]       ram_rdata;
  logic                             out_free;
  logic                             out_valid_q, out_valid_d;
  logic [deqd_pkg::WordW-1:0]       out_word_q, out_word_d;
  logic [deqd_pkg::CountW-1:0]      out_count_q, out_count_d;
  deqd_pkg::status_e                out_status_q, out_status_d;

  deqd_ram #(
    .Width (deqd_pkg::WordW),
    .Depth (deqd_pkg::Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  deqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (deqd_pkg::cmd_e'(s_axis_tuser_i)),
    .in_value_i  (s_axis_tdata_i),
    .res_free_i  (out_free),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    if (out_free) begin
      out_valid_d = res.valid;
      if (res.valid) begin
        out_word_d   = res.word;
        out_count_d  = res.count;
        out_status_d = res.status;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q   <= out_word_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_word_q};
  assign m_axis_tuser_o  = out_status_q;

  localparam logic [deqd_pkg::CountW-1:0] DepthCount = deqd_pkg::CountW'(deqd_pkg::Depth);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("Item accepted while another is in progress.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[38:32] <= DepthCount)
    else $error("Entry count beyond capacity.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == deqd_pkg::StEmpty)
      |-> (m_axis_tdata_o[31:0] == '0) && (m_axis_tdata_o[38:32] == '0))
    else $error("Pop on empty with a word or a nonzero count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == deqd_pkg::StFull)
      |-> m_axis_tdata_o[38:32] == DepthCount)
    else $error("Full status while the queue is not full.");

endmodule
